>>> src/are_pkg.sv
// Shared types and constants for the ack/retransmit engine.
`timescale 1ns / 1ps

package are_pkg;

  localparam int OP_W    = 3;
  localparam int ADDR_W  = 64;
  localparam int SEQ_W   = 8;
  localparam int LIMIT_W = 5;
  localparam int BASE_W  = 8;
  localparam int TIMER_W = 16;
  localparam int HOLD_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int STATUS_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 3'd0,
    OP_SEND   = 3'd1,
    OP_DATA   = 3'd2,
    OP_ACK    = 3'd3,
    OP_STATUS = 3'd4
  } opcode_t;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE        = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD        = 2'd3;

  localparam logic [STATUS_W-1:0] ST_NOT_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SUCCEEDED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_QUEUED    = 2'd2;

  localparam logic [LIMIT_W-1:0] RESET_LIMIT = 5'd20;
  localparam logic [BASE_W-1:0]  RESET_BASE  = 8'd4;
  localparam logic [HOLD_W-1:0]  RESET_HOLD  = 16'd80;

  // Request to the iterative period shifter.
  typedef struct packed {
    logic               start;
    logic [BASE_W-1:0]  base;
    logic [LIMIT_W-1:0] shift;
  } period_req_t;

endpackage

>>> src/ack_retransmit_engine_top.sv
// Top level of the stop-and-wait ack/retransmit engine with duplicate filter.
`timescale 1ns / 1ps

// Usage:
//   s_* carries one command word: tuser holds the opcode (tick, send request,
//   received data, received ack, status read), tdata the peer address, seq and
//   the addressed_to_me and link_busy flags. Every accepted word yields exactly
//   one result word on m_*. cfg_* writes enable, retry_limit, base_timeout and
//   dup_hold_time; write only while the engine is idle. cfg_ready is always high.
//   One word is worked on at a time; s_tready is high only between words.
//   Most words go from accept through S_RUN to S_DONE and m_tvalid. A tick that
//   rearms the retry timer and an accepted send also run the period shifter, which
//   shifts base_timeout one bit per cycle by (retry_limit - tries_left) /
//   TRIES_PER_SHIFT. A first received data word per tick also scans the duplicate
//   ring, one entry a cycle through one compare.
//   Reset clears the sender state, the duplicate ring and the output and loads the register defaults; no clearing pass.
//   A result waits in the output register while m_tready is low; the next word
//   is still taken and worked on, and stalls only when its own result is ready.
module ack_retransmit_engine_top #(
  parameter int DUP_ENTRIES     = 3,
  parameter int TRIES_PER_SHIFT = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [63:0] address, [71:64] seq, [72] addressed_to_me, [73] link_busy, [79:74] zero
  input  logic [79:0] s_tdata,
  // [2:0] opcode
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] accepted, [8:1] seq_assigned, [9] is_new, [10] send_ack,
  // [74:11] ack_address, [82:75] ack_seq, [83] retransmit, [84] send_failed,
  // [86:85] send_status, [87] success_now
  output logic [87:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int IDX_W = (DUP_ENTRIES > 1) ? $clog2(DUP_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DUP_ENTRIES - 1);

  typedef enum logic [2:0] {S_IDLE, S_RUN, S_SHIFT, S_SCAN, S_DONE} state_t;

  state_t state;

  // configuration
  logic                          enable;
  logic [are_pkg::LIMIT_W-1:0]   retry_limit;
  logic [are_pkg::BASE_W-1:0]    base_timeout;
  logic [are_pkg::HOLD_W-1:0]    dup_hold_time;

  // latched command
  logic [are_pkg::OP_W-1:0]      in_op;
  logic [are_pkg::ADDR_W-1:0]    in_addr;
  logic [are_pkg::SEQ_W-1:0]     in_seq;
  logic                          in_to_me;
  logic                          in_busy;

  // sender state
  logic                          pending;
  logic                          retry_due;
  logic                          success_flag;
  logic                          success_recent;
  logic [are_pkg::TIMER_W-1:0]   retry_timer;
  logic [are_pkg::LIMIT_W-1:0]   tries_left;
  logic [are_pkg::SEQ_W-1:0]     next_seq;
  logic [are_pkg::ADDR_W-1:0]    pending_dest;
  logic [are_pkg::SEQ_W-1:0]     pending_seq;

  // receiver duplicate ring
  logic [are_pkg::ADDR_W-1:0]    seen_addr [DUP_ENTRIES];
  logic [are_pkg::SEQ_W-1:0]     seen_seq  [DUP_ENTRIES];
  logic [IDX_W-1:0]              seen_slot;
  logic [are_pkg::HOLD_W-1:0]    hold_timer;
  logic                          checked_this_tick;
  logic [IDX_W-1:0]              scan_idx;

  // result under construction
  logic                          res_accepted;
  logic [are_pkg::SEQ_W-1:0]     res_seq_assigned;
  logic                          res_is_new;
  logic                          res_send_ack;
  logic [are_pkg::ADDR_W-1:0]    res_ack_address;
  logic [are_pkg::SEQ_W-1:0]     res_ack_seq;
  logic                          res_retransmit;
  logic                          res_send_failed;
  logic [are_pkg::STATUS_W-1:0]  res_status;

  // tick and send decode
  logic [are_pkg::TIMER_W-1:0]   timer_dec;
  logic                          timer_runs;
  logic                          expire;
  logic [are_pkg::LIMIT_W-1:0]   tries_new;
  logic                          rearm;
  logic                          fail;
  logic                          retry_due_v;
  logic [are_pkg::HOLD_W-1:0]    hold_dec;
  logic                          send_take;
  logic [are_pkg::LIMIT_W-1:0]   tries_sel;
  logic [are_pkg::LIMIT_W-1:0]   diff;
  logic [are_pkg::LIMIT_W-1:0]   shift_amt;
  logic                          scan_hit;
  logic [IDX_W-1:0]              slot_inc;
  logic [are_pkg::SEQ_W-1:0]     seq_inc;

  are_pkg::period_req_t          preq;
  logic                          p_done;
  logic [are_pkg::TIMER_W-1:0]   p_period;

  always_comb begin
    timer_dec  = retry_timer - 1'b1;
    timer_runs = pending && (retry_timer != '0);
    expire     = timer_runs && (timer_dec == '0);
    tries_new  = (tries_left != '0) ? tries_left - 1'b1 : tries_left;
    rearm      = expire && (tries_new != '0);
    fail       = expire && (tries_new == '0);
    retry_due_v = retry_due || rearm;
    hold_dec   = hold_timer - 1'b1;
    send_take  = !pending && !in_busy;
    tries_sel  = (in_op == are_pkg::OP_SEND) ? retry_limit : tries_new;
    diff       = (retry_limit > tries_sel) ? retry_limit - tries_sel : '0;
    // quotient by constant compares: largest k with k * TRIES_PER_SHIFT <= diff
    shift_amt  = '0;
    for (int k = 1; k < 32; k++) begin
      if (32'(diff) >= k * TRIES_PER_SHIFT) shift_amt = k[are_pkg::LIMIT_W-1:0];
    end
    scan_hit   = (seen_seq[scan_idx] == in_seq) && (seen_addr[scan_idx] == in_addr);
    slot_inc   = (seen_slot == LAST_IDX) ? '0 : seen_slot + 1'b1;
    seq_inc    = next_seq + 1'b1;

    preq.start = 1'b0;
    preq.base  = base_timeout;
    preq.shift = shift_amt;
    if (state == S_RUN) begin
      case (in_op)
        are_pkg::OP_TICK: preq.start = enable && rearm;
        are_pkg::OP_SEND: preq.start = send_take;
        default:          preq.start = 1'b0;
      endcase
    end
  end

  are_period_unit u_period (
    .clk    (clk),
    .rst    (rst),
    .req    (preq),
    .done   (p_done),
    .period (p_period)
  );

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      enable            <= 1'b0;
      retry_limit       <= are_pkg::RESET_LIMIT;
      base_timeout      <= are_pkg::RESET_BASE;
      dup_hold_time     <= are_pkg::RESET_HOLD;
      pending           <= 1'b0;
      retry_due         <= 1'b0;
      success_flag      <= 1'b0;
      success_recent    <= 1'b0;
      retry_timer       <= '0;
      tries_left        <= '0;
      next_seq          <= '0;
      pending_dest      <= '0;
      pending_seq       <= '0;
      seen_slot         <= '0;
      hold_timer        <= '0;
      checked_this_tick <= 1'b0;
      scan_idx          <= '0;
      m_tvalid          <= 1'b0;
      m_tdata           <= '0;
      for (int i = 0; i < DUP_ENTRIES; i++) begin
        seen_addr[i] <= '0;
        seen_seq[i]  <= '0;
      end
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          are_pkg::CFG_ENABLE:      enable        <= cfg_data[0];
          are_pkg::CFG_RETRY_LIMIT: retry_limit   <= cfg_data[are_pkg::LIMIT_W-1:0];
          are_pkg::CFG_BASE:        base_timeout  <= cfg_data[are_pkg::BASE_W-1:0];
          are_pkg::CFG_HOLD:        dup_hold_time <= cfg_data[are_pkg::HOLD_W-1:0];
          default:                  ;
        endcase
      end

      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            in_op            <= s_tuser;
            in_addr          <= s_tdata[63:0];
            in_seq           <= s_tdata[71:64];
            in_to_me         <= s_tdata[72];
            in_busy          <= s_tdata[73];
            res_accepted     <= 1'b0;
            res_seq_assigned <= '0;
            res_is_new       <= 1'b0;
            res_send_ack     <= 1'b0;
            res_ack_address  <= '0;
            res_ack_seq      <= '0;
            res_retransmit   <= 1'b0;
            res_send_failed  <= 1'b0;
            res_status       <= are_pkg::ST_NOT_DONE;
            state            <= S_RUN;
          end
        end

        S_RUN: begin
          // run the shifter or the ring scan where the word needs them
          if (preq.start) begin
            state <= S_SHIFT;
          end else if ((in_op == are_pkg::OP_DATA) && in_to_me && !checked_this_tick) begin
            state <= S_SCAN;
          end else begin
            state <= S_DONE;
          end
          case (in_op)
            are_pkg::OP_TICK: begin
              if (enable) begin
                checked_this_tick <= 1'b0;
                success_recent    <= 1'b0;
                if (hold_timer != '0) begin
                  hold_timer <= hold_dec;
                  if (hold_dec == '0) begin
                    for (int i = 0; i < DUP_ENTRIES; i++) begin
                      seen_seq[i] <= '0;
                    end
                    seen_slot <= '0;
                  end
                end
                res_retransmit  <= retry_due_v && !in_busy;
                res_send_failed <= fail;
                if (fail) begin
                  // drop the send
                  pending      <= 1'b0;
                  retry_due    <= 1'b0;
                  retry_timer  <= '0;
                  tries_left   <= '0;
                  success_flag <= 1'b0;
                end else begin
                  if (timer_runs) begin
                    retry_timer <= timer_dec;
                  end
                  if (expire) begin
                    tries_left <= tries_new;
                  end
                  retry_due <= retry_due_v && in_busy;
                end
              end
            end

            are_pkg::OP_SEND: begin
              if (send_take) begin
                pending          <= 1'b1;
                retry_due        <= 1'b0;
                next_seq         <= seq_inc;
                pending_seq      <= seq_inc;
                pending_dest     <= in_addr;
                tries_left       <= retry_limit;
                res_accepted     <= 1'b1;
                res_seq_assigned <= seq_inc;
              end
            end

            are_pkg::OP_DATA: begin
              if (in_to_me) begin
                if (!in_busy) begin
                  res_send_ack    <= 1'b1;
                  res_ack_address <= in_addr;
                  res_ack_seq     <= in_seq;
                end
                if (checked_this_tick) begin
                  res_is_new <= 1'b1;
                end else begin
                  checked_this_tick <= 1'b1;
                  scan_idx          <= '0;
                end
              end
            end

            are_pkg::OP_ACK: begin
              if (in_to_me && pending && (in_addr == pending_dest) &&
                  (in_seq == pending_seq)) begin
                success_flag   <= 1'b1;
                success_recent <= 1'b1;
                pending        <= 1'b0;
                retry_due      <= 1'b0;
                retry_timer    <= '0;
                tries_left     <= '0;
              end
            end

            are_pkg::OP_STATUS: begin
              if (pending) begin
                res_status <= are_pkg::ST_QUEUED;
              end else if (success_flag) begin
                success_flag <= 1'b0;
                res_status   <= are_pkg::ST_SUCCEEDED;
              end else begin
                res_status <= are_pkg::ST_NOT_DONE;
              end
            end

            default: ;
          endcase
        end

        S_SHIFT: begin
          if (p_done) begin
            retry_timer <= p_period;
            state       <= S_DONE;
          end
        end

        S_SCAN: begin
          if (scan_hit) begin
            res_is_new <= 1'b0;
            state      <= S_DONE;
          end else if (scan_idx == LAST_IDX) begin
            // no match anywhere: record the packet at the ring slot
            seen_seq[seen_slot]  <= in_seq;
            seen_addr[seen_slot] <= in_addr;
            seen_slot            <= slot_inc;
            hold_timer           <= dup_hold_time;
            res_is_new           <= 1'b1;
            state                <= S_DONE;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end

        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {success_recent, res_status, res_send_failed, res_retransmit,
                         res_ack_seq, res_ack_address, res_send_ack, res_is_new,
                         res_seq_assigned, res_accepted};
            state    <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> src/are_period_unit.sv
// Iterative saturating shifter: retry period = base << shift, clamped to the timer range.
`timescale 1ns / 1ps

module are_period_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  are_pkg::period_req_t          req,
  output logic                          done,
  output logic [are_pkg::TIMER_W-1:0]   period
);

  logic                          active;
  logic [are_pkg::LIMIT_W-1:0]   cnt;
  logic [are_pkg::TIMER_W-1:0]   val;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
      val    <= '0;
    end else if (req.start) begin
      active <= 1'b1;
      cnt    <= req.shift;
      val    <= {{(are_pkg::TIMER_W - are_pkg::BASE_W){1'b0}}, req.base};
    end else if (active) begin
      if (cnt == '0) begin
        active <= 1'b0;
      end else begin
        // one bit per cycle; saturate once the top bit would fall off
        val <= val[are_pkg::TIMER_W-1] ? {are_pkg::TIMER_W{1'b1}}
                                        : {val[are_pkg::TIMER_W-2:0], 1'b0};
        cnt <= cnt - 1'b1;
      end
    end
  end

  assign done   = active && (cnt == '0);
  assign period = val;

endmodule

>>> sim/arq_checker.sv
// Checker for the ack/retransmit engine: predicts each result word and compares it.
`timescale 1ns / 1ps

module arq_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  // [63:0] address, [71:64] seq, [72] addressed_to_me, [73] link_busy, [79:74] zero
  input  logic [79:0] s_tdata,
  // [2:0] opcode
  input  logic [2:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  // [0] accepted, [8:1] seq_assigned, [9] is_new, [10] send_ack,
  // [74:11] ack_address, [82:75] ack_seq, [83] retransmit, [84] send_failed,
  // [86:85] send_status, [87] success_now
  input  logic [87:0] m_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          errors,
  output int          words_in_flight
);

  localparam int RING_DEPTH     = 3;
  localparam int TRIES_PER_STEP = 4;
  localparam int MAX_REPORTS    = 40;

  typedef struct packed {
    logic                         success_now;
    logic [are_pkg::STATUS_W-1:0] send_status;
    logic                         send_failed;
    logic                         retransmit;
    logic [are_pkg::SEQ_W-1:0]    ack_seq;
    logic [are_pkg::ADDR_W-1:0]   ack_address;
    logic                         send_ack;
    logic                         is_new;
    logic [are_pkg::SEQ_W-1:0]    seq_assigned;
    logic                         accepted;
  } arq_result_t;

  // register copy
  logic                        en_q;
  logic [are_pkg::LIMIT_W-1:0] limit_q;
  logic [are_pkg::BASE_W-1:0]  base_q;
  logic [are_pkg::HOLD_W-1:0]  hold_q;

  // sender side
  logic                        send_open;
  logic                        resend_owed;
  logic                        delivered_flag;
  logic                        delivered_recent;
  logic [are_pkg::TIMER_W-1:0] rto_count;
  logic [are_pkg::LIMIT_W-1:0] tries_rem;
  logic [are_pkg::SEQ_W-1:0]   seq_ctr;
  logic [are_pkg::SEQ_W-1:0]   open_seq;
  logic [are_pkg::ADDR_W-1:0]  open_dest;

  // receiver duplicate ring
  logic [are_pkg::ADDR_W-1:0]  ring_addr [RING_DEPTH];
  logic [are_pkg::SEQ_W-1:0]   ring_seq  [RING_DEPTH];
  int unsigned                 ring_wr;
  logic [are_pkg::HOLD_W-1:0]  ring_life;
  logic                        ring_checked;

  arq_result_t result_q[$];
  arq_result_t got;
  arq_result_t want;
  int          err_count = 0;
  int          queued_n  = 0;

  assign errors          = err_count;
  assign words_in_flight = queued_n;

  task automatic report_mismatch(string what);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("%0t ns: %s", $time, what);
  endtask

  task automatic check_field(string name, logic [63:0] got_v, logic [63:0] want_v);
    if (got_v !== want_v)
      report_mismatch($sformatf("%s: got %0h, want %0h", name, got_v, want_v));
  endtask

  function automatic logic [are_pkg::TIMER_W-1:0] rto_period(
      logic [are_pkg::LIMIT_W-1:0] tries);
    logic [are_pkg::LIMIT_W-1:0] gap;
    logic [31:0]                 span;
    gap  = (limit_q > tries) ? limit_q - tries : '0;
    span = 32'(base_q) << (gap / TRIES_PER_STEP);
    return (span > 32'hFFFF) ? 16'hFFFF : span[are_pkg::TIMER_W-1:0];
  endfunction

  function automatic void close_send();
    send_open   = 1'b0;
    resend_owed = 1'b0;
    rto_count   = '0;
    tries_rem   = '0;
  endfunction

  function automatic void wipe_ring_seq();
    for (int k = 0; k < RING_DEPTH; k++) ring_seq[k] = '0;
    ring_wr   = 0;
    ring_life = '0;
  endfunction

  // Search the ring; on a miss, insert at the write slot and restart the hold time.
  function automatic logic ring_lookup_insert(logic [are_pkg::ADDR_W-1:0] addr,
                                              logic [are_pkg::SEQ_W-1:0] sq);
    logic hit;
    hit          = 1'b0;
    ring_checked = 1'b1;
    for (int k = 0; k < RING_DEPTH; k++)
      if (ring_seq[k] == sq && ring_addr[k] == addr) hit = 1'b1;
    if (hit) return 1'b0;
    if (ring_wr >= RING_DEPTH) ring_wr = 0;
    ring_seq[ring_wr]  = sq;
    ring_addr[ring_wr] = addr;
    ring_wr++;
    if (ring_wr >= RING_DEPTH) ring_wr = 0;
    ring_life = hold_q;
    return 1'b1;
  endfunction

  function automatic void load_defaults();
    en_q             = 1'b0;
    limit_q          = are_pkg::RESET_LIMIT;
    base_q           = are_pkg::RESET_BASE;
    hold_q           = are_pkg::RESET_HOLD;
    send_open        = 1'b0;
    resend_owed      = 1'b0;
    delivered_flag   = 1'b0;
    delivered_recent = 1'b0;
    ring_checked     = 1'b0;
    rto_count        = '0;
    tries_rem        = '0;
    seq_ctr          = '0;
    open_seq         = '0;
    open_dest        = '0;
    for (int k = 0; k < RING_DEPTH; k++) ring_addr[k] = '0;
    wipe_ring_seq();
  endfunction

  function automatic void write_reg(logic [are_pkg::CFG_IDX_W-1:0] idx,
                                    logic [are_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      are_pkg::CFG_ENABLE:      en_q    = data[0];
      are_pkg::CFG_RETRY_LIMIT: limit_q = data[are_pkg::LIMIT_W-1:0];
      are_pkg::CFG_BASE:        base_q  = data[are_pkg::BASE_W-1:0];
      are_pkg::CFG_HOLD:        hold_q  = data[are_pkg::HOLD_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic arq_result_t engine_step(logic [are_pkg::OP_W-1:0] op,
                                              logic [are_pkg::ADDR_W-1:0] addr,
                                              logic [are_pkg::SEQ_W-1:0] sq,
                                              logic me, logic busy);
    arq_result_t r;
    r = '0;
    case (op)
      are_pkg::OP_TICK: begin
        if (en_q) begin
          ring_checked     = 1'b0;
          delivered_recent = 1'b0;
          if (send_open && rto_count != 0) begin
            rto_count--;
            if (rto_count == 0) begin
              if (tries_rem != 0) tries_rem--;
              if (tries_rem != 0) begin
                resend_owed = 1'b1;
                rto_count   = rto_period(tries_rem);
              end else begin
                r.send_failed = 1'b1;
              end
            end
          end
          if (ring_life != 0) begin
            ring_life--;
            if (ring_life == 0) wipe_ring_seq();
          end
          if (resend_owed && !busy) begin
            resend_owed  = 1'b0;
            r.retransmit = 1'b1;
          end
          if (r.send_failed) begin
            close_send();
            delivered_flag = 1'b0;
          end
        end
      end
      are_pkg::OP_SEND: begin
        if (!send_open && !busy) begin
          send_open      = 1'b1;
          resend_owed    = 1'b0;
          seq_ctr        = seq_ctr + 1'b1;
          open_seq       = seq_ctr;
          open_dest      = addr;
          tries_rem      = limit_q;
          rto_count      = rto_period(limit_q);
          r.accepted     = 1'b1;
          r.seq_assigned = seq_ctr;
        end
      end
      are_pkg::OP_DATA: begin
        if (me) begin
          if (!busy) begin
            r.send_ack    = 1'b1;
            r.ack_address = addr;
            r.ack_seq     = sq;
          end
          // only the first data word after a tick goes through the ring
          if (ring_checked) r.is_new = 1'b1;
          else r.is_new = ring_lookup_insert(addr, sq);
        end
      end
      are_pkg::OP_ACK: begin
        if (me && send_open && addr == open_dest && sq == open_seq) begin
          delivered_flag   = 1'b1;
          delivered_recent = 1'b1;
          close_send();
        end
      end
      are_pkg::OP_STATUS: begin
        if (send_open) begin
          r.send_status = are_pkg::ST_QUEUED;
        end else if (delivered_flag) begin
          delivered_flag = 1'b0;
          r.send_status  = are_pkg::ST_SUCCEEDED;
        end else begin
          r.send_status = are_pkg::ST_NOT_DONE;
        end
      end
      default: ;
    endcase
    r.success_now = delivered_recent;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      load_defaults();
      result_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) write_reg(cfg_index, cfg_data);
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (result_q.size() == 0) begin
          report_mismatch($sformatf("result word %0h with nothing expected", m_tdata));
        end else begin
          want = result_q.pop_front();
          check_field("accepted", 64'(got.accepted), 64'(want.accepted));
          check_field("seq_assigned", 64'(got.seq_assigned), 64'(want.seq_assigned));
          check_field("is_new", 64'(got.is_new), 64'(want.is_new));
          check_field("send_ack", 64'(got.send_ack), 64'(want.send_ack));
          check_field("ack_address", got.ack_address, want.ack_address);
          check_field("ack_seq", 64'(got.ack_seq), 64'(want.ack_seq));
          check_field("retransmit", 64'(got.retransmit), 64'(want.retransmit));
          check_field("send_failed", 64'(got.send_failed), 64'(want.send_failed));
          check_field("send_status", 64'(got.send_status), 64'(want.send_status));
          check_field("success_now", 64'(got.success_now), 64'(want.success_now));
        end
      end
      if (s_tvalid && s_tready)
        result_q.push_back(engine_step(s_tuser, s_tdata[63:0], s_tdata[71:64],
                                       s_tdata[72], s_tdata[73]));
    end
    queued_n <= result_q.size();
  end

endmodule

>>> sim/tb_top.sv
// Testbench top for the ack/retransmit engine: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

  localparam logic [are_pkg::OP_W-1:0]   OP_FIRST_UNUSED = 3'd5;
  localparam logic [are_pkg::OP_W-1:0]   OP_LAST_UNUSED  = 3'd7;
  localparam logic [are_pkg::ADDR_W-1:0] ADDR_ONES       = '1;
  localparam int LONG_STALL       = 300;
  localparam int SETTLE           = 16;
  localparam int PHASE_PLAIN      = 0;
  localparam int PHASE_LONG_STALL = 1;
  localparam int PHASE_PAUSE      = 2;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata   = '0;
  logic [2:0]  s_tuser   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [87:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data  = '0;

  int errors;
  int in_flight;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int stall_reqs  = 0;
  int stalls_seen = 0;
  int stall_left  = 0;

  logic [are_pkg::ADDR_W-1:0] peers [4];
  logic [are_pkg::ADDR_W-1:0] last_dest = '0;
  logic [are_pkg::SEQ_W-1:0]  last_seq  = '0;

  always #5 clk = ~clk;

  ack_retransmit_engine_top u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  arq_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .errors          (errors),
    .words_in_flight (in_flight)
  );

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (stall_reqs != stalls_seen) begin
      stalls_seen <= stall_reqs;
      stall_left  <= LONG_STALL;
      m_tready    <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Track the last sequence handed out so acks can hit the pending send.
  always @(posedge clk) begin
    if (m_tvalid && m_tready && m_tdata[0]) last_seq <= m_tdata[8:1];
  end

  task automatic put_word(logic [are_pkg::OP_W-1:0] op, logic [are_pkg::ADDR_W-1:0] addr,
                          logic [are_pkg::SEQ_W-1:0] sq, logic me, logic busy);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {6'b0, busy, me, sq, addr};
    do @(posedge clk); while (!s_tready);
  endtask

  // Hold the input until every result word has come back, then let the block settle.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (in_flight != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_regs(logic en, logic [are_pkg::LIMIT_W-1:0] lim,
                          logic [are_pkg::BASE_W-1:0] base,
                          logic [are_pkg::HOLD_W-1:0] hold);
    logic [are_pkg::CFG_IDX_W-1:0]  idx  [4];
    logic [are_pkg::CFG_DATA_W-1:0] vals [4];
    idx[0]  = are_pkg::CFG_ENABLE;
    idx[1]  = are_pkg::CFG_RETRY_LIMIT;
    idx[2]  = are_pkg::CFG_BASE;
    idx[3]  = are_pkg::CFG_HOLD;
    vals[0] = 16'(en);
    vals[1] = 16'(lim);
    vals[2] = 16'(base);
    vals[3] = hold;
    for (int k = 0; k < 4; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= vals[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic random_word();
    int                         pick;
    int                         roll;
    int unsigned                draw;
    logic [are_pkg::OP_W-1:0]   op;
    logic [are_pkg::ADDR_W-1:0] a;
    logic [are_pkg::SEQ_W-1:0]  q;
    logic                       me;
    logic                       bz;
    pick = $urandom_range(99);
    roll = $urandom_range(99);
    me   = ($urandom_range(99) < 85);
    bz   = ($urandom_range(99) < 20);
    draw = $urandom_range(3);
    a    = ($urandom_range(99) < 80) ? peers[draw[1:0]] : {$urandom, $urandom};
    draw = $urandom;
    q    = draw[are_pkg::SEQ_W-1:0];
    if (pick < 35) begin
      op = are_pkg::OP_TICK;
    end else if (pick < 50) begin
      op        = are_pkg::OP_SEND;
      last_dest = a;
    end else if (pick < 70) begin
      // small sequence range so duplicates show up often
      op = are_pkg::OP_DATA;
      if (roll < 70) begin
        draw = $urandom_range(3);
        q    = draw[are_pkg::SEQ_W-1:0];
      end
    end else if (pick < 85) begin
      op = are_pkg::OP_ACK;
      if ($urandom_range(1) == 0) a = last_dest;
      if (roll < 60) q = last_seq;
      else if (roll < 80) q = last_seq + 1'b1;
    end else if (pick < 97) begin
      op = are_pkg::OP_STATUS;
    end else begin
      draw = $urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED);
      op   = draw[are_pkg::OP_W-1:0];
    end
    put_word(op, a, q, me, bz);
  endtask

  task automatic run_phase(logic en, logic [are_pkg::LIMIT_W-1:0] lim,
                           logic [are_pkg::BASE_W-1:0] base,
                           logic [are_pkg::HOLD_W-1:0] hold,
                           int idle, int stall, int n, int mode);
    drain();
    set_regs(en, lim, base, hold);
    idle_pct   = idle;
    stall_pct <= stall;
    for (int k = 0; k < n; k++) begin
      if (k == n / 2 && mode == PHASE_LONG_STALL) stall_reqs <= stall_reqs + 1;
      if (k == n / 2 && mode == PHASE_PAUSE) drain();
      random_word();
    end
  endtask

  initial begin
    foreach (peers[k]) peers[k] = {$urandom, $urandom};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // defaults, engine disabled: ticks and unused opcodes are ignored
    put_word(are_pkg::OP_STATUS, '0, '0, 1'b0, 1'b0);
    put_word(are_pkg::OP_TICK, '0, '0, 1'b0, 1'b0);
    put_word(OP_FIRST_UNUSED, ADDR_ONES, 8'hFF, 1'b1, 1'b1);
    put_word(OP_LAST_UNUSED, '0, '0, 1'b0, 1'b0);
    put_word(are_pkg::OP_SEND, ADDR_ONES, '0, 1'b0, 1'b1);
    put_word(are_pkg::OP_SEND, ADDR_ONES, '0, 1'b0, 1'b0);
    put_word(are_pkg::OP_SEND, '0, '0, 1'b0, 1'b0);
    put_word(are_pkg::OP_STATUS, '0, '0, 1'b0, 1'b0);
    put_word(are_pkg::OP_ACK, ADDR_ONES, 8'd2, 1'b1, 1'b0);
    put_word(are_pkg::OP_ACK, ADDR_ONES, 8'd1, 1'b0, 1'b0);
    put_word(are_pkg::OP_ACK, ADDR_ONES, 8'd1, 1'b1, 1'b1);
    put_word(are_pkg::OP_STATUS, '0, '0, 1'b0, 1'b0);
    put_word(are_pkg::OP_STATUS, '0, '0, 1'b0, 1'b0);
    put_word(are_pkg::OP_ACK, ADDR_ONES, 8'd1, 1'b1, 1'b0);
    // the ring starts out holding all-zero entries
    put_word(are_pkg::OP_DATA, '0, '0, 1'b1, 1'b0);
    put_word(are_pkg::OP_DATA, ADDR_ONES, 8'hFF, 1'b1, 1'b1);
    put_word(are_pkg::OP_DATA, ADDR_ONES, 8'hFF, 1'b0, 1'b0);

    // zero limit fails at the first expiry; zero hold time keeps the ring
    drain();
    set_regs(1'b1, 5'd0, 8'd1, 16'd0);
    put_word(are_pkg::OP_TICK, '0, '0, 1'b0, 1'b0);
    put_word(are_pkg::OP_DATA, ADDR_ONES, 8'hFF, 1'b1, 1'b0);
    put_word(are_pkg::OP_DATA, ADDR_ONES, 8'hFF, 1'b1, 1'b0);
    put_word(are_pkg::OP_TICK, '0, '0, 1'b0, 1'b0);
    put_word(are_pkg::OP_DATA, ADDR_ONES, 8'hFF, 1'b1, 1'b0);
    put_word(are_pkg::OP_SEND, peers[0], '0, 1'b0, 1'b0);
    put_word(are_pkg::OP_TICK, '0, '0, 1'b0, 1'b0);

    // zero base: the timer never runs, only an ack ends the send
    drain();
    set_regs(1'b1, 5'd2, 8'd0, 16'd1);
    put_word(are_pkg::OP_SEND, peers[1], '0, 1'b0, 1'b0);
    put_word(are_pkg::OP_DATA, peers[1], 8'h5A, 1'b1, 1'b0);
    put_word(are_pkg::OP_TICK, '0, '0, 1'b0, 1'b0);
    put_word(are_pkg::OP_TICK, '0, '0, 1'b0, 1'b0);
    put_word(are_pkg::OP_STATUS, '0, '0, 1'b0, 1'b0);
    put_word(are_pkg::OP_ACK, peers[1], 8'd3, 1'b1, 1'b0);

    // lower the limit under a live send, then hold a retransmit behind a busy link
    drain();
    set_regs(1'b1, 5'd8, 8'd1, 16'd80);
    put_word(are_pkg::OP_SEND, peers[2], '0, 1'b0, 1'b0);
    drain();
    set_regs(1'b1, 5'd1, 8'd1, 16'd80);
    put_word(are_pkg::OP_TICK, '0, '0, 1'b0, 1'b1);
    put_word(are_pkg::OP_TICK, '0, '0, 1'b0, 1'b0);

    run_phase(1'b1, 5'd3, 8'd2, 16'd12, 0, 0, 250, PHASE_PLAIN);
    run_phase(1'b1, 5'd1, 8'd1, 16'd1, 50, 0, 250, PHASE_PLAIN);
    run_phase(1'b1, 5'd6, 8'd3, 16'd40, 0, 50, 250, PHASE_LONG_STALL);
    run_phase(1'b1, 5'd31, 8'd255, 16'd65535, 19, 19, 200, PHASE_PLAIN);
    run_phase(1'b0, 5'd2, 8'd1, 16'd1, 0, 0, 50, PHASE_PLAIN);
    run_phase(1'b1, 5'd4, 8'd1, 16'd20, 19, 19, 250, PHASE_PAUSE);
    drain();

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
